// ===== src/co2br_pkg.sv =====
package co2br_pkg;

	localparam int unsigned PPM_W     = 16;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned FAIL_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 112;

	localparam logic [PPM_W-1:0] FRC_FAIL  = 16'hFFFF;
	localparam logic [PPM_W-1:0] CORR_BIAS = 16'h8000;
	localparam logic [PPM_W-1:0] MIN_INIT  = 16'hFFFF;

	localparam logic [PPM_W-1:0] RST_BASELINE      = 16'd400;
	localparam logic [PPM_W-1:0] RST_FIRST_OFFSET  = 16'd1000;
	localparam logic [PPM_W-1:0] RST_INIT_OFFSET   = 16'd200;
	localparam logic [PPM_W-1:0] RST_STEADY_OFFSET = 16'd50;
	localparam logic [PPM_W-1:0] RST_FIRST_LEN     = 16'd12;
	localparam logic [PPM_W-1:0] RST_INIT_LEN      = 16'd144;
	localparam logic [PPM_W-1:0] RST_STEADY_LEN    = 16'd1008;

	typedef enum logic [1:0] {
		CMD_READING = 2'd0,
		CMD_MEASURE = 2'd1,
		CMD_OTHER   = 2'd2,
		CMD_RESET   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_INIT   = 2'd1,
		PH_STEADY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_READY  = 3'd1,
		ST_SENSOR_ERR = 3'd2,
		ST_CAL_FAIL   = 3'd3,
		ST_PERIOD_END = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASELINE      = 3'd0,
		CFG_FIRST_OFFSET  = 3'd1,
		CFG_INIT_OFFSET   = 3'd2,
		CFG_STEADY_OFFSET = 3'd3,
		CFG_FIRST_LEN     = 3'd4,
		CFG_INIT_LEN      = 3'd5,
		CFG_STEADY_LEN    = 3'd6
	} cfg_idx_t;

endpackage

// ===== src/co2_baseline_recalibration_fsm.sv =====
// A word accepted on s_ waits in the input register and moves to the result
// register, raising m_tvalid, once that register is free.
// Throughput: one word per cycle while m_tready is high; a held result lets one
// more word into the input register, then s_tready drops until it drains.
// Reset (arst_n low, asynchronous): config registers take their defaults,
// phase first, period reloaded with the first-phase length, counters cleared.
module co2_baseline_recalibration_fsm
	import co2br_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] data_ready, [1] op_ok, [17:2] co2_ppm, [33:18] frc_reply, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] cmd
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] status, [3] frc_issued, [19:4] frc_target, [35:20] last_correction,
	// [67:36] frc_count, [99:68] frc_age, [107:100] fail_count, [109:108] phase
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PPM_W-1:0]      cfg_data
);

	logic [PPM_W-1:0] baseline_q, first_off_q, init_off_q, steady_off_q;
	logic [PPM_W-1:0] first_len_q, init_len_q, steady_len_q;

	phase_t            phase_q;
	logic [PPM_W-1:0]  left_q, min_q, corr_q;
	logic              spent_q;
	logic [FAIL_W-1:0] fail_q;
	logic [CNT_W-1:0]  total_q, age_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              ready_s1, ok_s1;
	logic [PPM_W-1:0]  co2_s1, reply_s1;

	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              advance;

	phase_t            n_phase, ph_next;
	logic [PPM_W-1:0]  n_left, n_min, n_corr, min_new;
	logic              n_spent;
	logic [FAIL_W-1:0] n_fail, fail_inc;
	logic [CNT_W-1:0]  n_total, n_age;
	status_t           status;
	logic              issued;
	logic [PPM_W-1:0]  target;

	logic [PPM_W-1:0]  lim_cur, lim_new, len_new, diff, below_tgt, shift, end_tgt;
	logic              below, over;

	function automatic logic [PPM_W-1:0] sel3(phase_t ph, logic [PPM_W-1:0] a,
			logic [PPM_W-1:0] b, logic [PPM_W-1:0] c);
		logic [PPM_W-1:0] r;
		unique case (ph)
			PH_FIRST: r = a;
			PH_INIT:  r = b;
			default:  r = c;
		endcase
		return r;
	endfunction

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_comb begin
		unique case (phase_q)
			PH_FIRST: ph_next = PH_INIT;
			default:  ph_next = PH_STEADY;
		endcase
		lim_cur   = sel3(phase_q, first_off_q, init_off_q, steady_off_q);
		lim_new   = sel3(ph_next, first_off_q, init_off_q, steady_off_q);
		len_new   = sel3(ph_next, first_len_q, init_len_q, steady_len_q);
		below     = co2_s1 < baseline_q;
		diff      = baseline_q - co2_s1;
		below_tgt = (diff > lim_cur) ? co2_s1 + lim_cur : baseline_q;
		min_new   = (co2_s1 < min_q) ? co2_s1 : min_q;
		over      = (min_new < baseline_q) || ((min_new - baseline_q) > lim_new);
		shift     = over ? lim_new : min_new - baseline_q;
		end_tgt   = co2_s1 - shift;
		fail_inc  = (fail_q != '1) ? fail_q + 1'b1 : fail_q;

		n_phase = phase_q;
		n_left  = left_q;
		n_min   = min_q;
		n_spent = spent_q;
		n_fail  = fail_q;
		n_age   = age_q;
		status  = ST_OK;
		issued  = 1'b0;
		target  = '0;

		unique case (cmd_s1)
			CMD_READING: begin
				if (!ready_s1) begin
					status = ST_NOT_READY;
				end else if (!ok_s1 || co2_s1 == '0) begin
					n_fail = fail_inc;
					status = ST_SENSOR_ERR;
				end else begin
					n_fail = '0;
					n_min  = min_new;
					n_age  = age_q + 1'b1;
					if (below) begin
						n_spent = 1'b1;
						issued  = 1'b1;
						target  = below_tgt;
					end
					if (below && reply_s1 == FRC_FAIL) begin
						status = ST_CAL_FAIL;
					end else if (left_q <= 16'd1) begin
						n_phase = ph_next;
						n_left  = len_new;
						n_min   = MIN_INIT;
						if (below || spent_q) begin
							n_spent = 1'b0;
						end else begin
							issued = 1'b1;
							target = end_tgt;
							n_age  = '0;
							if (reply_s1 == FRC_FAIL)
								status = ST_CAL_FAIL;
						end
					end else begin
						n_left = left_q - 1'b1;
					end
				end
			end
			CMD_MEASURE: begin
				if (!ok_s1) begin
					n_fail = fail_inc;
					status = ST_SENSOR_ERR;
				end else if (left_q <= 16'd1) begin
					status = ST_PERIOD_END;
				end else begin
					n_fail = '0;
				end
			end
			CMD_OTHER: begin
				if (!ok_s1) begin
					n_fail = fail_inc;
					status = ST_SENSOR_ERR;
				end else begin
					n_fail = '0;
				end
			end
			default: begin
				n_phase = PH_FIRST;
				n_spent = 1'b0;
				n_min   = MIN_INIT;
				n_left  = first_len_q;
				n_fail  = '0;
			end
		endcase

		n_total = issued ? total_q + 1'b1 : total_q;
		n_corr  = issued ? reply_s1 - CORR_BIAS : corr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q   <= RST_BASELINE;
			first_off_q  <= RST_FIRST_OFFSET;
			init_off_q   <= RST_INIT_OFFSET;
			steady_off_q <= RST_STEADY_OFFSET;
			first_len_q  <= RST_FIRST_LEN;
			init_len_q   <= RST_INIT_LEN;
			steady_len_q <= RST_STEADY_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASELINE:      baseline_q   <= cfg_data;
				CFG_FIRST_OFFSET:  first_off_q  <= cfg_data;
				CFG_INIT_OFFSET:   init_off_q   <= cfg_data;
				CFG_STEADY_OFFSET: steady_off_q <= cfg_data;
				CFG_FIRST_LEN:     first_len_q  <= cfg_data;
				CFG_INIT_LEN:      init_len_q   <= cfg_data;
				CFG_STEADY_LEN:    steady_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_FIRST;
			left_q      <= RST_FIRST_LEN;
			min_q       <= MIN_INIT;
			spent_q     <= 1'b0;
			fail_q      <= '0;
			total_q     <= '0;
			age_q       <= '0;
			corr_q      <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= n_phase;
				left_q      <= n_left;
				min_q       <= n_min;
				spent_q     <= n_spent;
				fail_q      <= n_fail;
				total_q     <= n_total;
				age_q       <= n_age;
				corr_q      <= n_corr;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= cmd_t'(s_tuser);
			ready_s1 <= s_tdata[0];
			ok_s1    <= s_tdata[1];
			co2_s1   <= s_tdata[17:2];
			reply_s1 <= s_tdata[33:18];
		end
		if (advance)
			out_data_q <= {2'b00, n_phase, n_fail, n_age, n_total, n_corr, target,
				issued, status};
	end

endmodule

// ===== src/co2br_checker.sv =====
module co2br_checker
	import co2br_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// held word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3] || m_tdata[19:4] == '0))
		else $error("target set without recalibration");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_CAL_FAIL |-> m_tdata[3])
		else $error("calibration failure without recalibration");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_SENSOR_ERR |-> m_tdata[107:100] != '0)
		else $error("sensor error with zero failure count");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_CAL_FAIL)
		else $error("recalibration with unexpected status");

endmodule

bind co2_baseline_recalibration_fsm co2br_checker u_co2br_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
